>>> hw/rtl/cas_pkg.sv
package cas_pkg;

   // Timing defaults for the two auto-mode hold-off windows, in ms.
   localparam logic [31:0] FAN_HOLD_MS_DEF  = 32'd60000;
   localparam logic [31:0] PUMP_HOLD_MS_DEF = 32'd300000;

   // Stream widths.
   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   // CSR port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // CSR reset values.
   localparam logic signed [11:0] TEMP_HIGH_RST    = 12'sd300;
   localparam logic signed [11:0] TEMP_RECOVER_RST = 12'sd280;
   localparam logic [9:0]         HUM_HIGH_RST     = 10'd850;
   localparam logic [9:0]         HUM_RECOVER_RST  = 10'd750;
   localparam logic [9:0]         MOISTURE_LOW_RST = 10'd300;
   localparam logic [9:0]         TANK_LOW_RST     = 10'd200;
   localparam logic [9:0]         TANK_FULL_RST    = 10'd900;
   localparam logic [31:0]        PUMP_RUN_MS_RST  = 32'd10000;

   typedef enum logic [2:0] {
      REG_TEMP_HIGH    = 3'd0,
      REG_TEMP_RECOVER = 3'd1,
      REG_HUM_HIGH     = 3'd2,
      REG_HUM_RECOVER  = 3'd3,
      REG_MOISTURE_LOW = 3'd4,
      REG_TANK_LOW     = 3'd5,
      REG_TANK_FULL    = 3'd6,
      REG_PUMP_RUN_MS  = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_SENSOR = 3'd0,
      OP_MODE   = 3'd1,
      OP_FAN    = 3'd2,
      OP_PUMP   = 3'd3,
      OP_REFILL = 3'd4
   } op_type;

   typedef struct packed {
      logic signed [11:0] temp_high;
      logic signed [11:0] temp_recover;
      logic [9:0]         hum_high;
      logic [9:0]         hum_recover;
      logic [9:0]         moisture_low;
      logic [9:0]         tank_low;
      logic [9:0]         tank_full;
      logic [31:0]        pump_run_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [31:0]        now_ms;
      logic [9:0]         moisture;
      logic [9:0]         water_level;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
      logic               mode_value;
      logic               switch_on;
      logic [31:0]        run_for_ms;
   } event_type;

   typedef struct packed {
      logic fan_on;
      logic water_pump_on;
      logic refill_pump_on;
      logic auto_mode;
      logic changed;
   } result_type;

endpackage

>>> hw/rtl/cas_csr.sv
module cas_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cas_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cas_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cas_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output cas_pkg::cfg_type                cfg
);

   cas_pkg::cfg_type     cfg_ff;
   cas_pkg::cfg_type     cfg_in;
   cas_pkg::csr_reg_type reg_sel;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = cas_pkg::csr_reg_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            cas_pkg::REG_TEMP_HIGH:    cfg_in.temp_high    = $signed(csr_pwdata[11:0]);
            cas_pkg::REG_TEMP_RECOVER: cfg_in.temp_recover = $signed(csr_pwdata[11:0]);
            cas_pkg::REG_HUM_HIGH:     cfg_in.hum_high     = csr_pwdata[9:0];
            cas_pkg::REG_HUM_RECOVER:  cfg_in.hum_recover  = csr_pwdata[9:0];
            cas_pkg::REG_MOISTURE_LOW: cfg_in.moisture_low = csr_pwdata[9:0];
            cas_pkg::REG_TANK_LOW:     cfg_in.tank_low     = csr_pwdata[9:0];
            cas_pkg::REG_TANK_FULL:    cfg_in.tank_full    = csr_pwdata[9:0];
            cas_pkg::REG_PUMP_RUN_MS:  cfg_in.pump_run_ms  = csr_pwdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         cas_pkg::REG_TEMP_HIGH:    csr_prdata = {20'd0, cfg_ff.temp_high};
         cas_pkg::REG_TEMP_RECOVER: csr_prdata = {20'd0, cfg_ff.temp_recover};
         cas_pkg::REG_HUM_HIGH:     csr_prdata = {22'd0, cfg_ff.hum_high};
         cas_pkg::REG_HUM_RECOVER:  csr_prdata = {22'd0, cfg_ff.hum_recover};
         cas_pkg::REG_MOISTURE_LOW: csr_prdata = {22'd0, cfg_ff.moisture_low};
         cas_pkg::REG_TANK_LOW:     csr_prdata = {22'd0, cfg_ff.tank_low};
         cas_pkg::REG_TANK_FULL:    csr_prdata = {22'd0, cfg_ff.tank_full};
         cas_pkg::REG_PUMP_RUN_MS:  csr_prdata = cfg_ff.pump_run_ms;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_high    <= cas_pkg::TEMP_HIGH_RST;
         cfg_ff.temp_recover <= cas_pkg::TEMP_RECOVER_RST;
         cfg_ff.hum_high     <= cas_pkg::HUM_HIGH_RST;
         cfg_ff.hum_recover  <= cas_pkg::HUM_RECOVER_RST;
         cfg_ff.moisture_low <= cas_pkg::MOISTURE_LOW_RST;
         cfg_ff.tank_low     <= cas_pkg::TANK_LOW_RST;
         cfg_ff.tank_full    <= cas_pkg::TANK_FULL_RST;
         cfg_ff.pump_run_ms  <= cas_pkg::PUMP_RUN_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/cas_core.sv
module cas_core #(
   parameter logic [31:0] FAN_HOLD_MS  = cas_pkg::FAN_HOLD_MS_DEF,
   parameter logic [31:0] PUMP_HOLD_MS = cas_pkg::PUMP_HOLD_MS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  cas_pkg::event_type    evt,
   input  cas_pkg::cfg_type      cfg,
   output cas_pkg::result_type   result
);

   // Actuator and timer state.
   logic        mode_auto_ff,    mode_auto_in;
   logic        fan_state_ff,    fan_state_in;
   logic        fan_by_auto_ff,  fan_by_auto_in;
   logic        pump_state_ff,   pump_state_in;
   logic        refill_state_ff, refill_state_in;
   logic [31:0] fan_last_ff,     fan_last_in;
   logic [31:0] pump_stop_ff,    pump_stop_in;
   logic [31:0] pump_start_ff,   pump_start_in;

   cas_pkg::op_type op;
   logic        chg;
   logic        hot, cool, tank_ok;
   logic        fan_gap_ok, pump_gap_ok, pump_due;
   logic [31:0] fan_elapsed, pump_elapsed, auto_stop, manual_stop;

   assign op           = cas_pkg::op_type'(evt.operation);
   assign fan_elapsed  = evt.now_ms - fan_last_ff;
   assign pump_elapsed = evt.now_ms - pump_start_ff;
   assign fan_gap_ok   = fan_elapsed >= FAN_HOLD_MS;
   assign pump_gap_ok  = (pump_elapsed >= PUMP_HOLD_MS) || (pump_start_ff == '0);
   assign pump_due     = evt.now_ms >= pump_stop_ff;
   assign auto_stop    = evt.now_ms + cfg.pump_run_ms;
   assign manual_stop  = evt.now_ms + evt.run_for_ms;
   assign hot  = ($signed(evt.temperature) > $signed(cfg.temp_high)) ||
                 (evt.humidity > cfg.hum_high);
   assign cool = ($signed(evt.temperature) <= $signed(cfg.temp_recover)) &&
                 (evt.humidity <= cfg.hum_recover);
   assign tank_ok = (evt.water_level >= cfg.tank_low) && !refill_state_ff;

   always_comb begin
      mode_auto_in    = mode_auto_ff;
      fan_state_in    = fan_state_ff;
      fan_by_auto_in  = fan_by_auto_ff;
      pump_state_in   = pump_state_ff;
      refill_state_in = refill_state_ff;
      fan_last_in     = fan_last_ff;
      pump_stop_in    = pump_stop_ff;
      pump_start_in   = pump_start_ff;
      chg             = 1'b0;
      case (op)
         cas_pkg::OP_SENSOR: begin
            // Pump timer runs out in either mode.
            if (pump_state_ff && pump_due) begin
               pump_state_in = 1'b0;
               chg           = 1'b1;
            end
            if (mode_auto_ff) begin
               if (hot && !fan_state_ff) begin
                  if (fan_gap_ok || (fan_last_ff == '0)) begin
                     fan_state_in   = 1'b1;
                     fan_by_auto_in = 1'b1;
                     fan_last_in    = evt.now_ms;
                     chg            = 1'b1;
                  end
               end else if (cool && fan_state_ff && fan_by_auto_ff) begin
                  if (fan_gap_ok) begin
                     fan_state_in   = 1'b0;
                     fan_by_auto_in = 1'b0;
                     fan_last_in    = evt.now_ms;
                     chg            = 1'b1;
                  end
               end
               // Irrigation may restart in the same beat the timer expired.
               if (!pump_state_in && (evt.moisture < cfg.moisture_low) && tank_ok &&
                   pump_gap_ok) begin
                  pump_state_in = 1'b1;
                  pump_stop_in  = auto_stop;
                  pump_start_in = evt.now_ms;
                  chg           = 1'b1;
               end
               if (!refill_state_ff && (evt.water_level < cfg.tank_low)) begin
                  refill_state_in = 1'b1;
                  chg             = 1'b1;
               end else if (refill_state_ff && (evt.water_level >= cfg.tank_full)) begin
                  refill_state_in = 1'b0;
                  chg             = 1'b1;
               end
            end
         end
         cas_pkg::OP_MODE: begin
            if (evt.mode_value != mode_auto_ff) begin
               mode_auto_in = evt.mode_value;
               // To manual: drop auto's fan, refill, pump if auto ever ran it.
               if (!evt.mode_value) begin
                  if (fan_by_auto_ff && fan_state_ff) begin
                     fan_state_in   = 1'b0;
                     fan_by_auto_in = 1'b0;
                  end
                  if (pump_state_ff && (pump_start_ff != '0)) begin
                     pump_state_in = 1'b0;
                     pump_stop_in  = '0;
                  end
                  refill_state_in = 1'b0;
               end
            end
         end
         cas_pkg::OP_FAN: begin
            if (fan_state_ff != evt.switch_on) begin
               fan_state_in   = evt.switch_on;
               fan_by_auto_in = 1'b0;
            end
         end
         cas_pkg::OP_PUMP: begin
            pump_state_in = evt.switch_on;
            pump_stop_in  = evt.switch_on ? manual_stop : '0;
         end
         cas_pkg::OP_REFILL: begin
            refill_state_in = evt.switch_on;
         end
         default: begin
            chg = 1'b0;
         end
      endcase
   end

   assign result.fan_on         = fan_state_in;
   assign result.water_pump_on  = pump_state_in;
   assign result.refill_pump_on = refill_state_in;
   assign result.auto_mode      = mode_auto_in;
   assign result.changed        = chg;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_auto_ff    <= 1'b1;
         fan_state_ff    <= 1'b0;
         fan_by_auto_ff  <= 1'b0;
         pump_state_ff   <= 1'b0;
         refill_state_ff <= 1'b0;
         fan_last_ff     <= '0;
         pump_stop_ff    <= '0;
         pump_start_ff   <= '0;
      end else if (step) begin
         mode_auto_ff    <= mode_auto_in;
         fan_state_ff    <= fan_state_in;
         fan_by_auto_ff  <= fan_by_auto_in;
         pump_state_ff   <= pump_state_in;
         refill_state_ff <= refill_state_in;
         fan_last_ff     <= fan_last_in;
         pump_stop_ff    <= pump_stop_in;
         pump_start_ff   <= pump_start_in;
      end
   end

   a_fan_auto_implies_on: assert property (@(posedge clock) disable iff (reset)
      fan_by_auto_ff |-> fan_state_ff)
      else $error("fan marked auto-started while off");

   a_manual_sensor_no_pump_start: assert property (@(posedge clock) disable iff (reset)
      (step && (op == cas_pkg::OP_SENSOR) && !mode_auto_ff) |=>
         (!pump_state_ff || $past(pump_state_ff)))
      else $error("sensor beat started the pump in manual mode");

   a_manual_drops_refill: assert property (@(posedge clock) disable iff (reset)
      (step && (op == cas_pkg::OP_MODE) && mode_auto_ff && !evt.mode_value) |=>
         (!refill_state_ff && !mode_auto_ff))
      else $error("refill pump survived switch to manual");

endmodule

>>> hw/rtl/climate_actuator_sequencer_unit.sv
// Channel  | Dir | Handshake            | Payload
// req_     | in  | req_tvalid/tready    | tdata: event fields, tuser: operation
// rsp_     | out | rsp_tvalid/tready    | tdata: actuator bits and changed flag
// csr_     | in  | APB psel/penable     | 8 registers at byte address 4*index
//
// One beat per cycle sustained while rsp_tready is high; rsp_tvalid is registered.
// Beats pass through an input register, then one pass of compare/add logic that
// updates the actuator state and loads the result register in the same edge.
// Reset (synchronous) clears both holding registers, sets auto mode and turns
// every actuator off; CSRs return to their defaults.
// A stalled rsp side holds the result register; the input register then stays
// put and req_tready drops only while both registers are full and rsp_tready is low.
module climate_actuator_sequencer_unit #(
   parameter logic [31:0] FAN_HOLD_MS  = cas_pkg::FAN_HOLD_MS_DEF,
   parameter logic [31:0] PUMP_HOLD_MS = cas_pkg::PUMP_HOLD_MS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // now_ms[31:0], moisture[41:32], water_level[51:42], temperature[63:52],
   // humidity[73:64], mode_value[74], switch_on[75], run_for_ms[107:76], zero pad
   input  logic [cas_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[2:0]
   input  logic [cas_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // fan_on[0], water_pump_on[1], refill_pump_on[2], auto_mode[3], changed[4], zero pad
   output logic [cas_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cas_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cas_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cas_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   cas_pkg::cfg_type    cfg;
   cas_pkg::event_type  evt_ff, evt_in;
   cas_pkg::result_type result;
   logic                evt_valid_ff, evt_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [4:0]          rsp_bits_ff;
   logic                advance;
   logic                req_fire;

   // Move the held event into the result register when the output slot frees up.
   assign advance    = evt_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !evt_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign evt_valid_in = req_fire || (evt_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Unpack the incoming beat.
   always_comb begin
      evt_in.operation   = req_tuser;
      evt_in.now_ms      = req_tdata[31:0];
      evt_in.moisture    = req_tdata[41:32];
      evt_in.water_level = req_tdata[51:42];
      evt_in.temperature = $signed(req_tdata[63:52]);
      evt_in.humidity    = req_tdata[73:64];
      evt_in.mode_value  = req_tdata[74];
      evt_in.switch_on   = req_tdata[75];
      evt_in.run_for_ms  = req_tdata[107:76];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_bits_ff};

   cas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cas_core #(
      .FAN_HOLD_MS  (FAN_HOLD_MS),
      .PUMP_HOLD_MS (PUMP_HOLD_MS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .evt    (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: event on accept, result bits on advance; hold otherwise.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         evt_ff <= evt_in;
      end
      if (advance) begin
         rsp_bits_ff <= {result.changed, result.auto_mode, result.refill_pump_on,
                         result.water_pump_on, result.fan_on};
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (evt_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input beat accepted with both stages blocked");

   a_advance_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat did not reach the result register");

   a_stall_keeps_event: assert property (@(posedge clock) disable iff (reset)
      (evt_valid_ff && !advance) |=> (evt_valid_ff && $stable(evt_ff)))
      else $error("held event lost while output stalled");

endmodule

>>> test/tb_climate_actuator_sequencer_unit.sv
module tb_climate_actuator_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Give up when no beat moves on either side for this many cycles.
   localparam int QUIET_LIMIT = 2000;
   localparam logic [2:0] OP_FIRST_UNUSED = cas_pkg::OP_REFILL + 3'd1;

   localparam cas_pkg::cfg_type DEFAULT_SETTINGS = '{
      temp_high: cas_pkg::TEMP_HIGH_RST, temp_recover: cas_pkg::TEMP_RECOVER_RST,
      hum_high: cas_pkg::HUM_HIGH_RST, hum_recover: cas_pkg::HUM_RECOVER_RST,
      moisture_low: cas_pkg::MOISTURE_LOW_RST, tank_low: cas_pkg::TANK_LOW_RST,
      tank_full: cas_pkg::TANK_FULL_RST, pump_run_ms: cas_pkg::PUMP_RUN_MS_RST};

   // Bottom of every documented range: no irrigation, zero-length auto runs.
   localparam cas_pkg::cfg_type LOWEST_SETTINGS = '{
      temp_high: -12'sd400, temp_recover: -12'sd400, hum_high: 10'd0, hum_recover: 10'd0,
      moisture_low: 10'd0, tank_low: 10'd0, tank_full: 10'd0, pump_run_ms: 32'd0};

   // Top of every documented range: the auto stop time wraps for any nonzero now_ms.
   localparam cas_pkg::cfg_type HIGHEST_SETTINGS = '{
      temp_high: 12'sd1250, temp_recover: 12'sd1250, hum_high: 10'd1000,
      hum_recover: 10'd1000, moisture_low: 10'd1000, tank_low: 10'd1000,
      tank_full: 10'd1000, pump_run_ms: 32'hFFFF_FFFF};

   // Full register width, out of range: inverted tank refill window on purpose.
   localparam cas_pkg::cfg_type FULL_WIDTH_SETTINGS = '{
      temp_high: 12'sh7FF, temp_recover: 12'sh800, hum_high: 10'h3FF, hum_recover: 10'h000,
      moisture_low: 10'h3FF, tank_low: 10'h3FF, tank_full: 10'h000,
      pump_run_ms: 32'h8000_0000};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;

   logic [cas_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic [cas_pkg::REQ_USER_W-1:0]  req_tuser = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cas_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [cas_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [cas_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [cas_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   // Knobs for the current traffic phase, in percent of cycles.
   int                              idle_pct = 0;
   int                              stall_pct = 0;

   // Predicted sequencer state, mirrors what the block should hold.
   cas_pkg::cfg_type                cfg = DEFAULT_SETTINGS;
   logic                            auto_on = 1'b1;
   logic                            fan_running = 1'b0;
   logic                            fan_from_auto = 1'b0;
   logic                            pump_running = 1'b0;
   logic                            refill_running = 1'b0;
   logic [31:0]                     fan_switch_ms = '0;
   logic [31:0]                     pump_stop_ms = '0;
   logic [31:0]                     pump_start_ms = '0;

   cas_pkg::result_type             expected_actuators[$];
   logic [31:0]                     wall_ms = '0;
   int                              mismatch_count = 0;
   int                              beat_count = 0;
   int                              beat_count_seen = 0;
   int                              quiet_cycles = 0;

   climate_actuator_sequencer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Apply one event to the predicted state and return the actuator bits it leaves.
   function automatic cas_pkg::result_type advance_climate(cas_pkg::event_type ev);
      logic                flipped;
      logic                hot;
      logic                cool;
      cas_pkg::result_type r;
      flipped = 1'b0;
      case (ev.operation)
         cas_pkg::OP_SENSOR: begin
            // Timer expiry is a plain unsigned compare, in either mode.
            if (pump_running && ev.now_ms >= pump_stop_ms) begin
               pump_running = 1'b0;
               flipped = 1'b1;
            end
            if (auto_on) begin
               hot  = ($signed(ev.temperature) > $signed(cfg.temp_high)) ||
                      (ev.humidity > cfg.hum_high);
               cool = ($signed(ev.temperature) <= $signed(cfg.temp_recover)) &&
                      (ev.humidity <= cfg.hum_recover);
               // A start held off by the switching gap blocks the stop check.
               if (hot && !fan_running) begin
                  if (32'(ev.now_ms - fan_switch_ms) >= cas_pkg::FAN_HOLD_MS_DEF ||
                      fan_switch_ms == '0) begin
                     fan_running = 1'b1;
                     fan_from_auto = 1'b1;
                     fan_switch_ms = ev.now_ms;
                     flipped = 1'b1;
                  end
               end else if (cool && fan_running && fan_from_auto) begin
                  if (32'(ev.now_ms - fan_switch_ms) >= cas_pkg::FAN_HOLD_MS_DEF) begin
                     fan_running = 1'b0;
                     fan_from_auto = 1'b0;
                     fan_switch_ms = ev.now_ms;
                     flipped = 1'b1;
                  end
               end
               if (!pump_running && ev.moisture < cfg.moisture_low &&
                   ev.water_level >= cfg.tank_low && !refill_running) begin
                  if (32'(ev.now_ms - pump_start_ms) >= cas_pkg::PUMP_HOLD_MS_DEF ||
                      pump_start_ms == '0) begin
                     pump_running = 1'b1;
                     pump_stop_ms = ev.now_ms + cfg.pump_run_ms;
                     pump_start_ms = ev.now_ms;
                     flipped = 1'b1;
                  end
               end
               if (!refill_running && ev.water_level < cfg.tank_low) begin
                  refill_running = 1'b1;
                  flipped = 1'b1;
               end else if (refill_running && ev.water_level >= cfg.tank_full) begin
                  refill_running = 1'b0;
                  flipped = 1'b1;
               end
            end
         end
         cas_pkg::OP_MODE: begin
            if (ev.mode_value != auto_on) begin
               auto_on = ev.mode_value;
               // Going manual drops what auto mode owns; any past auto start
               // makes a running pump count as owned, hand runs included.
               if (!ev.mode_value) begin
                  if (fan_from_auto && fan_running) begin
                     fan_running = 1'b0;
                     fan_from_auto = 1'b0;
                  end
                  if (pump_running && pump_start_ms != '0) begin
                     pump_running = 1'b0;
                     pump_stop_ms = '0;
                  end
                  refill_running = 1'b0;
               end
            end
         end
         cas_pkg::OP_FAN: begin
            if (fan_running != ev.switch_on) begin
               fan_running = ev.switch_on;
               fan_from_auto = 1'b0;
            end
         end
         cas_pkg::OP_PUMP: begin
            pump_running = ev.switch_on;
            pump_stop_ms = ev.switch_on ? ev.now_ms + ev.run_for_ms : '0;
         end
         cas_pkg::OP_REFILL: refill_running = ev.switch_on;
         default: ;
      endcase
      r.fan_on = fan_running;
      r.water_pump_on = pump_running;
      r.refill_pump_on = refill_running;
      r.auto_mode = auto_on;
      r.changed = flipped;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Offer one event until it is taken; predict it at the accepting edge.
   task automatic send_event(cas_pkg::event_type ev);
      logic taken;
      taken = 1'b0;
      req_tvalid <= 1'b1;
      req_tuser <= ev.operation;
      req_tdata <= {4'b0, ev.run_for_ms, ev.switch_on, ev.mode_value, ev.humidity,
                    ev.temperature, ev.water_level, ev.moisture, ev.now_ms};
      while (!taken) begin
         // Sample mid-cycle: the block and this bench only move at the rising edge.
         @(negedge clock);
         if (req_tready) begin
            expected_actuators.push_back(advance_climate(ev));
            beat_count++;
            taken = 1'b1;
         end
         @(posedge clock);
      end
   endtask

   // Drop valid for a random number of cycles, per the phase's idle rate.
   task automatic pace_sender();
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold the sender until every predicted beat is back, then let the pipe drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_actuators.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(cas_pkg::csr_reg_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic apply_settings(cas_pkg::cfg_type c);
      write_csr(cas_pkg::REG_TEMP_HIGH, {{20{c.temp_high[11]}}, c.temp_high});
      write_csr(cas_pkg::REG_TEMP_RECOVER, {{20{c.temp_recover[11]}}, c.temp_recover});
      write_csr(cas_pkg::REG_HUM_HIGH, 32'(c.hum_high));
      write_csr(cas_pkg::REG_HUM_RECOVER, 32'(c.hum_recover));
      write_csr(cas_pkg::REG_MOISTURE_LOW, 32'(c.moisture_low));
      write_csr(cas_pkg::REG_TANK_LOW, 32'(c.tank_low));
      write_csr(cas_pkg::REG_TANK_FULL, 32'(c.tank_full));
      write_csr(cas_pkg::REG_PUMP_RUN_MS, c.pump_run_ms);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      cfg = c;
   endtask

   // Thresholds in a plausible order, recover at or below trigger.
   function automatic cas_pkg::cfg_type sane_settings();
      cas_pkg::cfg_type c;
      c.temp_high = 12'(150 + int'($urandom_range(250)));
      c.temp_recover = 12'(int'(c.temp_high) - int'($urandom_range(60)));
      c.hum_high = 10'(600 + $urandom_range(350));
      c.hum_recover = 10'(c.hum_high - $urandom_range(150));
      c.moisture_low = 10'(100 + $urandom_range(500));
      c.tank_low = 10'(50 + $urandom_range(300));
      c.tank_full = 10'(c.tank_low + $urandom_range(1000 - c.tank_low));
      c.pump_run_ms = $urandom_range(200000, 1000);
      return c;
   endfunction

   // Mostly close to one of two thresholds so hysteresis edges get hit often.
   function automatic int sensor_reading(int thr_a, int thr_b, int lo, int hi);
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         return thr_a + int'($urandom_range(80)) - 40;
      if (pick < 70)
         return thr_b + int'($urandom_range(80)) - 40;
      if (pick < 95)
         return lo + int'($urandom_range(hi - lo));
      return int'($urandom);
   endfunction

   function automatic cas_pkg::event_type random_event();
      cas_pkg::event_type ev;
      int                 pick;
      // Advance wall time: short hops, hops around the fan gap, around the pump
      // gap, and now and then a jump anywhere (wraps, going backward).
      case ($urandom_range(9))
         0, 1, 2, 3: wall_ms += $urandom_range(3000);
         4, 5, 6:    wall_ms += $urandom_range(80000, 20000);
         7, 8:       wall_ms += $urandom_range(400000, 100000);
         default:    wall_ms = $urandom;
      endcase
      ev.now_ms = wall_ms;
      ev.moisture = 10'(sensor_reading(cfg.moisture_low, cfg.moisture_low, 0, 1000));
      ev.water_level = 10'(sensor_reading(cfg.tank_low, cfg.tank_full, 0, 1000));
      ev.temperature = 12'(sensor_reading(int'(cfg.temp_high), int'(cfg.temp_recover),
                                          -400, 1250));
      ev.humidity = 10'(sensor_reading(cfg.hum_high, cfg.hum_recover, 0, 1000));
      ev.mode_value = ($urandom_range(99) < 75);
      ev.switch_on = 1'($urandom_range(1));
      ev.run_for_ms = ($urandom_range(99) < 80) ? $urandom_range(30000) : $urandom;
      pick = $urandom_range(99);
      if (pick < 62)
         ev.operation = cas_pkg::OP_SENSOR;
      else if (pick < 72)
         ev.operation = cas_pkg::OP_MODE;
      else if (pick < 80)
         ev.operation = cas_pkg::OP_FAN;
      else if (pick < 88)
         ev.operation = cas_pkg::OP_PUMP;
      else if (pick < 95)
         ev.operation = cas_pkg::OP_REFILL;
      else
         ev.operation = OP_FIRST_UNUSED + 3'($urandom_range(2));
      return ev;
   endfunction

   function automatic cas_pkg::event_type sensor_event_at(logic [31:0] now, int moist,
                                                          int level, int temp, int hum);
      cas_pkg::event_type ev;
      ev = '0;
      ev.operation = cas_pkg::OP_SENSOR;
      ev.now_ms = now;
      ev.moisture = 10'(moist);
      ev.water_level = 10'(level);
      ev.temperature = 12'(temp);
      ev.humidity = 10'(hum);
      return ev;
   endfunction

   function automatic cas_pkg::event_type command_event(logic [2:0] op, logic [31:0] now,
                                                        logic switch_to, logic mode,
                                                        logic [31:0] run_ms);
      cas_pkg::event_type ev;
      ev = '0;
      ev.operation = op;
      ev.now_ms = now;
      ev.switch_on = switch_to;
      ev.mode_value = mode;
      ev.run_for_ms = run_ms;
      return ev;
   endfunction

   task automatic run_random_events(int count);
      for (int i = 0; i < count; i++) begin
         // Halfway through, hold off until the block has answered everything.
         if (i == count / 2)
            settle();
         send_event(random_event());
         pace_sender();
      end
   endtask

   // Walk the corner cases at the reset settings, back to back.
   task automatic test_directed_cases();
      idle_pct = 0;
      stall_pct = 0;
      // A hand pump run survives going manual while auto never started one.
      send_event(command_event(cas_pkg::OP_PUMP, 32'd0, 1'b1, 1'b0, 32'd500));
      send_event(command_event(cas_pkg::OP_MODE, 32'd0, 1'b0, 1'b0, '0));
      send_event(command_event(cas_pkg::OP_MODE, 32'd0, 1'b0, 1'b1, '0));
      send_event(sensor_event_at(32'd0, 500, 500, 250, 500));
      // Fan starts on the hottest reading, stamp zero means never switched.
      send_event(sensor_event_at(32'd1000, 500, 500, 1250, 500));
      send_event(sensor_event_at(32'd2000, 500, 500, -400, 0));
      send_event(sensor_event_at(32'd61000, 500, 500, -400, 0));
      // Hot by humidity while the gap has not passed: start held off.
      send_event(sensor_event_at(32'd70000, 500, 500, 250, 1000));
      send_event(sensor_event_at(32'd121000, 0, 1000, 250, 1000));
      // Expiry at exactly the stop time; cooldown keeps the pump off.
      send_event(sensor_event_at(32'd131000, 0, 1000, 250, 500));
      send_event(sensor_event_at(32'd140000, 500, 0, 250, 500));
      // Dry soil but refill active: irrigation blocked.
      send_event(sensor_event_at(32'd500000, 0, 500, 250, 500));
      send_event(sensor_event_at(32'd510000, 500, 1000, 250, 500));
      // Manual fan: off, on by hand, then a repeat that changes nothing.
      send_event(command_event(cas_pkg::OP_FAN, 32'd520000, 1'b0, 1'b0, '0));
      send_event(command_event(cas_pkg::OP_FAN, 32'd520000, 1'b1, 1'b0, '0));
      send_event(command_event(cas_pkg::OP_FAN, 32'd520000, 1'b1, 1'b0, '0));
      // Stop time wraps below the start stamp, so the next update expires it.
      send_event(command_event(cas_pkg::OP_PUMP, 32'hFFFF_FFF0, 1'b1, 1'b0, 32'hFFFF_FFFF));
      send_event(sensor_event_at(32'hFFFF_FFF5, 500, 500, 250, 500));
      send_event(command_event(cas_pkg::OP_REFILL, 32'd600000, 1'b1, 1'b0, '0));
      send_event(command_event(cas_pkg::OP_PUMP, 32'd600000, 1'b1, 1'b0, 32'd50000));
      send_event(command_event(cas_pkg::OP_MODE, 32'd600000, 1'b0, 1'b1, '0));
      send_event(command_event(cas_pkg::OP_MODE, 32'd600000, 1'b0, 1'b0, '0));
      // Manual mode: a hot dry empty reading only runs the expiry check.
      send_event(sensor_event_at(32'd700000, 0, 0, 1250, 1000));
      send_event(command_event(cas_pkg::OP_PUMP, 32'd700000, 1'b1, 1'b0, 32'd0));
      send_event(sensor_event_at(32'd700000, 0, 0, 1250, 1000));
      // Unused encodings, lowest and highest: state shown, nothing done.
      send_event(command_event(OP_FIRST_UNUSED, 32'd700000, 1'b1, 1'b0, '1));
      send_event(command_event('1, 32'd700000, 1'b1, 1'b0, '1));
      send_event(command_event(cas_pkg::OP_MODE, 32'd800000, 1'b0, 1'b1, '0));
      send_event(command_event(cas_pkg::OP_PUMP, 32'd800000, 1'b0, 1'b0, '1));
      wall_ms = 32'd800000;
   endtask

   // Each register at both ends of its range and at full width.
   task automatic test_config_extremes();
      settle();
      apply_settings(LOWEST_SETTINGS);
      idle_pct = 35;
      stall_pct = 35;
      run_random_events(40);
      settle();
      apply_settings(HIGHEST_SETTINGS);
      run_random_events(40);
      settle();
      apply_settings(FULL_WIDTH_SETTINGS);
      run_random_events(40);
   endtask

   // Long random runs under each flow-control pattern.
   task automatic test_random_traffic();
      settle();
      apply_settings(DEFAULT_SETTINGS);
      idle_pct = 0;
      stall_pct = 0;
      run_random_events(150);
      settle();
      apply_settings(sane_settings());
      idle_pct = 59;
      stall_pct = 0;
      run_random_events(150);
      settle();
      apply_settings(sane_settings());
      idle_pct = 0;
      stall_pct = 59;
      run_random_events(150);
      settle();
      apply_settings(sane_settings());
      idle_pct = 35;
      stall_pct = 35;
      run_random_events(150);
   endtask

   // Randomize backpressure on the result side every cycle.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Compare each result beat with the oldest prediction, field by field.
   always @(negedge clock) begin : check_result
      cas_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beat_count++;
         if (expected_actuators.size() == 0) begin
            report_mismatch($sformatf("result beat %0h with no event pending", rsp_tdata));
         end else begin
            want = expected_actuators.pop_front();
            if (rsp_tdata[0] !== want.fan_on)
               report_mismatch($sformatf("fan_on got %b want %b", rsp_tdata[0], want.fan_on));
            if (rsp_tdata[1] !== want.water_pump_on)
               report_mismatch($sformatf("water_pump_on got %b want %b",
                                         rsp_tdata[1], want.water_pump_on));
            if (rsp_tdata[2] !== want.refill_pump_on)
               report_mismatch($sformatf("refill_pump_on got %b want %b",
                                         rsp_tdata[2], want.refill_pump_on));
            if (rsp_tdata[3] !== want.auto_mode)
               report_mismatch($sformatf("auto_mode got %b want %b",
                                         rsp_tdata[3], want.auto_mode));
            if (rsp_tdata[4] !== want.changed)
               report_mismatch($sformatf("changed got %b want %b",
                                         rsp_tdata[4], want.changed));
         end
      end
   end

   // Abort when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || beat_count != beat_count_seen) begin
         quiet_cycles <= 0;
         beat_count_seen <= beat_count;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("climate_actuator_sequencer_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_config_extremes();
      test_random_traffic();
      settle();
      // Give stray beats a chance to show up after the last expected one.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_actuators.size() == 0)
         $display("climate_actuator_sequencer_unit verification clean");
      else
         $display("climate_actuator_sequencer_unit verification failed");
      $finish;
   end

endmodule
